// ----- design/erlwq_pkg.sv -----
// ----------------------------------------------------------------------------
// erlwq_pkg
// Shared types, op codes and defaults for the event ring log window query.
// ----------------------------------------------------------------------------
package erlwq_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam logic [1:0] OP_RECORD = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] event_time;
      logic [7:0]  err_type;
      logic [31:0] err_id;
      logic [31:0] err_index;
      logic [6:0]  max_count;
      logic [31:0] start_time;
      logic [31:0] end_time;
   } req_type;

   typedef struct packed {
      logic        has_entry;
      logic [31:0] entry_time;
      logic [7:0]  entry_type;
      logic [31:0] entry_id;
      logic [31:0] entry_index;
      logic [31:0] oldest_time;
      logic [31:0] newest_time;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] time_val;
      logic [7:0]  type_val;
      logic [31:0] id_val;
      logic [31:0] index_val;
   } slot_type;

endpackage

// ----- design/erlwq_mem.sv -----
// ----------------------------------------------------------------------------
// erlwq_mem
// Ring storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module erlwq_mem #(
   parameter int DEPTH = erlwq_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  erlwq_pkg::slot_type        wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output erlwq_pkg::slot_type        rd_data
);
   import erlwq_pkg::*;

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/event_ring_log_window_query.sv -----
// ----------------------------------------------------------------------------
// event_ring_log_window_query
// Ring log of recent error events with overwrite of the oldest entry and a
// windowed query that walks the ring from the oldest entry.
// Record and clear are accepted back to back. A query holds the input
// (req_stall) until its last result is loaded into the result register;
// the walk passes S_READ and S_EVAL for each entry read, then S_DONE (also
// when the end bound stops it), and waits while the result register is
// stalled. The walk is set by the single memory read port, one read per step.
// Reset clears the pointers and the fill count; the stores are not cleared.
// ----------------------------------------------------------------------------
module event_ring_log_window_query #(
   parameter int DEPTH = erlwq_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  erlwq_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output erlwq_pkg::rsp_type rsp_payload
);
   import erlwq_pkg::*;

   localparam int AddrW = $clog2(DEPTH);
   localparam int CntW  = $clog2(DEPTH + 1);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(DEPTH - 1);
   localparam logic [CntW-1:0]  FullCnt  = CntW'(DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EVAL = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [AddrW-1:0] front_ff, front_in;
   logic [AddrW-1:0] rear_ff, rear_in;
   logic [AddrW-1:0] cur_ff, cur_in;
   logic [CntW-1:0]  fill_ff, fill_in;
   logic [CntW-1:0]  passed_ff, passed_in;
   logic [CntW-1:0]  n_ff, n_in;
   logic [CntW-1:0]  limit_ff, limit_in;
   logic             skip_ff, skip_in;
   logic [31:0]      start_ff, start_in;
   logic [31:0]      end_ff, end_in;
   logic [31:0]      oldest_ff, oldest_in;
   logic [31:0]      newest_ff, newest_in;
   logic             hold_valid_ff, hold_valid_in;
   slot_type         hold_ff, hold_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             out_free;
   logic             emit;
   rsp_type          emit_data;
   logic             wr_en;
   slot_type         wr_data;
   slot_type         rd_data;

   erlwq_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rear_ff),
      .wr_data (wr_data),
      .rd_addr (cur_ff),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign wr_en     = accept && (req_payload.op == OP_RECORD);

   assign wr_data.time_val  = req_payload.event_time;
   assign wr_data.type_val  = req_payload.err_type;
   assign wr_data.id_val    = req_payload.err_id;
   assign wr_data.index_val = req_payload.err_index;

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      cur_in        = cur_ff;
      fill_in       = fill_ff;
      passed_in     = passed_ff;
      n_in          = n_ff;
      limit_in      = limit_ff;
      skip_in       = skip_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      oldest_in     = oldest_ff;
      newest_in     = newest_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      emit          = 1'b0;
      emit_data     = '0;
      emit_data.oldest_time = oldest_ff;
      emit_data.newest_time = (fill_ff == '0) ? 32'd0 : newest_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_payload.op)
                  OP_RECORD: begin
                     rear_in   = (rear_ff == LastAddr) ? '0 : rear_ff + 1'b1;
                     newest_in = req_payload.event_time;
                     if (fill_ff == FullCnt) begin
                        front_in = (front_ff == LastAddr) ? '0 : front_ff + 1'b1;
                     end else begin
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     front_in = '0;
                     rear_in  = '0;
                     fill_in  = '0;
                  end
                  OP_QUERY: begin
                     cur_in    = front_ff;
                     passed_in = '0;
                     n_in      = '0;
                     skip_in   = (req_payload.start_time != 32'd0);
                     start_in  = req_payload.start_time;
                     end_in    = req_payload.end_time;
                     oldest_in = 32'd0;
                     if (req_payload.max_count != 7'd0 &&
                         req_payload.max_count < 7'(fill_ff)) begin
                        limit_in = CntW'(req_payload.max_count);
                     end else begin
                        limit_in = fill_ff;
                     end
                     state_in = S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (passed_ff == fill_ff || n_ff == limit_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (passed_ff == '0) begin
               oldest_in = rd_data.time_val;
            end
            if (skip_ff && rd_data.time_val < start_ff) begin
               passed_in = passed_ff + 1'b1;
               cur_in    = (cur_ff == LastAddr) ? '0 : cur_ff + 1'b1;
               state_in  = S_READ;
            end else begin
               skip_in = 1'b0;
               if (end_ff != 32'd0 && rd_data.time_val > end_ff) begin
                  state_in = S_DONE;
               end else if (!hold_valid_ff || out_free) begin
                  if (hold_valid_ff) begin
                     emit                  = 1'b1;
                     emit_data.has_entry   = 1'b1;
                     emit_data.entry_time  = hold_ff.time_val;
                     emit_data.entry_type  = hold_ff.type_val;
                     emit_data.entry_id    = hold_ff.id_val;
                     emit_data.entry_index = hold_ff.index_val;
                  end
                  hold_in       = rd_data;
                  hold_valid_in = 1'b1;
                  n_in          = n_ff + 1'b1;
                  passed_in     = passed_ff + 1'b1;
                  cur_in        = (cur_ff == LastAddr) ? '0 : cur_ff + 1'b1;
                  state_in      = S_READ;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_data.last = 1'b1;
               if (hold_valid_ff) begin
                  emit_data.has_entry   = 1'b1;
                  emit_data.entry_time  = hold_ff.time_val;
                  emit_data.entry_type  = hold_ff.type_val;
                  emit_data.entry_id    = hold_ff.id_val;
                  emit_data.entry_index = hold_ff.index_val;
               end
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_in       = emit ? emit_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         front_ff      <= '0;
         rear_ff       <= '0;
         fill_ff       <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skip_ff       <= 1'b0;
         passed_ff     <= '0;
         n_ff          <= '0;
         limit_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         rear_ff       <= rear_in;
         fill_ff       <= fill_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         skip_ff       <= skip_in;
         passed_ff     <= passed_in;
         n_ff          <= n_in;
         limit_ff      <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      oldest_ff <= oldest_in;
      newest_ff <= newest_in;
      hold_ff   <= hold_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FullCnt)
      else $error("fill count above depth");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_valid_ff)
      else $error("held entry left over after query");

   a_query_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.op == OP_QUERY) |=> req_stall)
      else $error("query did not hold the input");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (n_ff <= limit_ff && passed_ff <= fill_ff))
      else $error("query walk beyond limit");

endmodule
